FILE: sv/bpfa_pkg.sv
`timescale 1ns / 1ps
// shared constants, types and word-level helper functions for the page frame allocator
// no dependencies

package bpfa_pkg;

  localparam int MAX_FRAMES = 65536;
  localparam int MAX_RUN    = 256;
  localparam int WORD_BITS  = 64;

  localparam int MAP_WORDS = MAX_FRAMES / WORD_BITS;
  localparam int ADDR_W    = $clog2(MAP_WORDS);
  localparam int BIT_W     = $clog2(WORD_BITS);
  localparam int CNT_W     = $clog2(WORD_BITS + 1);
  localparam int LOG_W     = $clog2(BIT_W + 1);
  localparam int RUN_W     = $clog2(MAX_RUN + 1);

  localparam int FRAME_W  = 17;
  localparam int START_W  = 16;
  localparam int COUNT_W  = 9;
  localparam int STATUS_W = 2;
  localparam int GRANT_W  = 16;
  localparam int SCAN_W   = FRAME_W - BIT_W;

  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 3;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic REG_FRAME_COUNT = 1'b0;

  typedef logic [WORD_BITS-1:0] word_t;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK     = 2'd0,
    STATUS_NO_RUN = 2'd1,
    STATUS_ZERO   = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DECIDE,
    S_SCAN,
    S_MOD_RD,
    S_MOD_WR,
    S_RESP
  } state_t;

  // bit j set when lo <= base + j < hi
  function automatic word_t range_mask(input logic [FRAME_W-1:0] base,
                                       input logic [FRAME_W-1:0] lo,
                                       input logic [FRAME_W-1:0] hi);
    logic [FRAME_W-1:0] dl;
    logic [FRAME_W-1:0] dh;
    logic [CNT_W-1:0]   lo_off;
    logic [CNT_W-1:0]   hi_off;
    word_t              ones;
    dl   = lo - base;
    dh   = hi - base;
    ones = '1;
    if (lo <= base) begin
      lo_off = '0;
    end else if (dl >= FRAME_W'(WORD_BITS)) begin
      lo_off = CNT_W'(WORD_BITS);
    end else begin
      lo_off = dl[CNT_W-1:0];
    end
    if (hi <= base) begin
      hi_off = '0;
    end else if (dh >= FRAME_W'(WORD_BITS)) begin
      hi_off = CNT_W'(WORD_BITS);
    end else begin
      hi_off = dh[CNT_W-1:0];
    end
    return (ones << lo_off) & ~(ones << hi_off);
  endfunction

  // number of ones below the lowest zero
  function automatic logic [CNT_W-1:0] count_trailing(input word_t w);
    logic [CNT_W-1:0] c;
    c = CNT_W'(WORD_BITS);
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (!w[i]) c = CNT_W'(i);
    end
    return c;
  endfunction

  // number of ones above the highest zero
  function automatic logic [CNT_W-1:0] count_leading(input word_t w);
    logic [CNT_W-1:0] c;
    c = CNT_W'(WORD_BITS);
    for (int i = 0; i < WORD_BITS; i++) begin
      if (!w[i]) c = CNT_W'(WORD_BITS - 1 - i);
    end
    return c;
  endfunction

  function automatic logic [BIT_W-1:0] lowest_set(input word_t w);
    logic [BIT_W-1:0] idx;
    idx = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (w[i]) idx = BIT_W'(i);
    end
    return idx;
  endfunction

  // bit s set when f[s +: n] is all ones, n from 1 to WORD_BITS
  function automatic word_t run_starts(input word_t f, input logic [CNT_W-1:0] n);
    word_t [BIT_W:0]  p;
    logic [LOG_W-1:0] k;
    logic [CNT_W-1:0] rem;
    p[0] = f;
    for (int i = 1; i <= BIT_W; i++) begin
      p[i] = p[i-1] & (p[i-1] >> (1 << (i - 1)));
    end
    k = '0;
    for (int i = 0; i < CNT_W; i++) begin
      if (n[i]) k = LOG_W'(i);
    end
    rem = n - (CNT_W'(1) << k);
    return p[k] & (p[k] >> rem);
  endfunction

endpackage

FILE: sv/bpfa_ram.sv
`timescale 1ns / 1ps
// generic single-clock ram, one write port and one read port with registered read data
// no dependencies

module bpfa_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: sv/bitmap_page_frame_allocator.sv
`timescale 1ns / 1ps
// next-fit bitmap page frame allocator, top level
// depends on bpfa_pkg and bpfa_ram
//
// channel | ports                                           | direction
// in      | in_valid in_ready in_operation in_start_frame   | request in
//         | in_page_count                                   |
// out     | out_valid out_ready out_status out_granted_frame| result out
// cfg     | psel penable pwrite paddr pwdata prdata pready  | apb register port
//
// after reset a clearing pass sets all 1024 map words to used, no transfer in
// a request passes a decide step and a response step around the map word loop: a free
// reads and writes back each touched word, an allocate scans the words (up to two passes
// over the map) and then reads and writes back each marked word
// the map ram single read port sets the pace, one word per cycle in the scan
// a new request is taken while the previous result waits in the output register

module bitmap_page_frame_allocator (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                in_operation,
  input  logic [bpfa_pkg::START_W-1:0]        in_start_frame,
  input  logic [bpfa_pkg::COUNT_W-1:0]        in_page_count,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [bpfa_pkg::STATUS_W-1:0]       out_status,
  output logic [bpfa_pkg::GRANT_W-1:0]        out_granted_frame,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [bpfa_pkg::APB_ADDR_W-1:0]     paddr,
  input  logic [bpfa_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [bpfa_pkg::APB_DATA_W-1:0]     prdata,
  output logic                                pready
);

  localparam int FW = bpfa_pkg::FRAME_W;
  localparam int AW = bpfa_pkg::ADDR_W;
  localparam int BW = bpfa_pkg::BIT_W;
  localparam int CW = bpfa_pkg::CNT_W;
  localparam int RW = bpfa_pkg::RUN_W;

  bpfa_pkg::state_t  state_r, state_nxt;
  logic [FW-1:0]     frame_count_r;
  logic [AW-1:0]     clr_cnt_r, clr_cnt_nxt;
  logic              op_r;
  logic [bpfa_pkg::START_W-1:0] start_r;
  logic [bpfa_pkg::COUNT_W-1:0] count_r;
  logic [FW-1:0]     cursor_r, cursor_nxt;
  logic              pass_r, pass_nxt;
  logic [FW-1:0]     from_r, from_nxt;
  logic [bpfa_pkg::SCAN_W-1:0] issue_word_r, issue_word_nxt;
  logic [AW-1:0]     eval_word_r, eval_word_nxt;
  logic              eval_vld_r, eval_vld_nxt;
  logic [RW-1:0]     run_len_r, run_len_nxt;
  logic [FW-1:0]     run_start_r, run_start_nxt;
  logic [FW-1:0]     lo_r, lo_nxt;
  logic [FW-1:0]     hi_r, hi_nxt;
  logic [AW-1:0]     mod_word_r, mod_word_nxt;
  logic              set_r, set_nxt;
  bpfa_pkg::status_t status_r, status_nxt;
  logic [bpfa_pkg::GRANT_W-1:0] grant_r, grant_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [bpfa_pkg::STATUS_W-1:0] out_status_r, out_status_nxt;
  logic [bpfa_pkg::GRANT_W-1:0]  out_grant_r, out_grant_nxt;

  logic              cfg_wr;
  logic [FW-1:0]     limit;
  logic              in_xfer;
  bpfa_pkg::word_t   rd_data;
  bpfa_pkg::word_t   wr_data;
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  bpfa_pkg::word_t   ram_wdata;
  logic [AW-1:0]     ram_raddr;

  logic [FW-1:0]     issue_base;
  logic              issue_ok;
  logic [FW-1:0]     eval_base;
  bpfa_pkg::word_t   free_mask;
  logic [CW-1:0]     tz;
  logic [CW-1:0]     lz;
  bpfa_pkg::word_t   starts;
  logic              hit_a;
  logic              hit_b;
  logic [FW-1:0]     run_head;
  logic [FW-1:0]     found_frame;
  logic              found;
  logic              pass_end;
  logic [RW:0]       run_sum;
  logic [FW-1:0]     n_eff;
  logic [FW-1:0]     free_end;
  logic [FW-1:0]     free_hi;
  logic [FW-1:0]     fail_cursor;
  logic [FW-1:0]     mod_base;
  bpfa_pkg::word_t   mod_mask;
  logic [FW-1:0]     hi_m1;
  logic              mod_last;

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready &&
                  (paddr[bpfa_pkg::APB_ADDR_W-1] == bpfa_pkg::REG_FRAME_COUNT);
  assign prdata = (paddr[bpfa_pkg::APB_ADDR_W-1] == bpfa_pkg::REG_FRAME_COUNT) ?
                  bpfa_pkg::APB_DATA_W'(frame_count_r) : '0;

  assign limit = (frame_count_r > FW'(bpfa_pkg::MAX_FRAMES)) ?
                 FW'(bpfa_pkg::MAX_FRAMES) : frame_count_r;

  assign in_ready = (state_r == bpfa_pkg::S_IDLE);
  assign in_xfer  = in_valid && in_ready;

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_granted_frame = out_grant_r;

  // scan datapath
  assign issue_base = {issue_word_r, {BW{1'b0}}};
  assign issue_ok   = (state_r == bpfa_pkg::S_SCAN) && (issue_base < limit);
  assign eval_base  = FW'({eval_word_r, {BW{1'b0}}});
  assign free_mask  = ~rd_data & bpfa_pkg::range_mask(eval_base, from_r, limit);
  assign tz         = bpfa_pkg::count_trailing(free_mask);
  assign lz         = bpfa_pkg::count_leading(free_mask);
  assign starts     = (count_r <= bpfa_pkg::COUNT_W'(bpfa_pkg::WORD_BITS)) ?
                      bpfa_pkg::run_starts(free_mask, count_r[CW-1:0]) : '0;
  assign hit_a      = ({1'b0, run_len_r} + (RW+1)'(tz)) >= (RW+1)'(count_r);
  assign hit_b      = |starts;
  assign run_head   = (run_len_r == '0) ? eval_base : run_start_r;
  assign found_frame = hit_a ? run_head :
                       eval_base + FW'(bpfa_pkg::lowest_set(starts));
  assign found      = eval_vld_r && (hit_a || hit_b);
  assign pass_end   = !eval_vld_r && !issue_ok;
  assign run_sum    = (RW+1)'(run_len_r) + (RW+1)'(bpfa_pkg::WORD_BITS);

  assign n_eff       = (count_r > bpfa_pkg::COUNT_W'(bpfa_pkg::MAX_RUN)) ?
                       FW'(bpfa_pkg::MAX_RUN) : FW'(count_r);
  assign free_end    = FW'(start_r) + n_eff;
  assign free_hi     = (free_end < limit) ? free_end : limit;
  assign fail_cursor = (FW'(count_r) <= limit) ? (limit - FW'(count_r) + FW'(1)) : '0;

  // read-modify-write datapath
  assign mod_base = FW'({mod_word_r, {BW{1'b0}}});
  assign mod_mask = bpfa_pkg::range_mask(mod_base, lo_r, hi_r);
  assign hi_m1    = hi_r - FW'(1);
  assign mod_last = (mod_word_r == hi_m1[BW +: AW]);
  assign wr_data  = set_r ? (rd_data | mod_mask) : (rd_data & ~mod_mask);

  assign ram_we    = (state_r == bpfa_pkg::S_CLEAR) || (state_r == bpfa_pkg::S_MOD_WR);
  assign ram_waddr = (state_r == bpfa_pkg::S_CLEAR) ? clr_cnt_r : mod_word_r;
  assign ram_wdata = (state_r == bpfa_pkg::S_CLEAR) ? '1 : wr_data;
  assign ram_raddr = (state_r == bpfa_pkg::S_MOD_RD) ? mod_word_r : issue_word_r[AW-1:0];

  bpfa_ram #(
    .WIDTH (bpfa_pkg::WORD_BITS),
    .DEPTH (bpfa_pkg::MAP_WORDS)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (rd_data)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      bpfa_pkg::S_CLEAR: begin
        if (clr_cnt_r == AW'(bpfa_pkg::MAP_WORDS - 1)) state_nxt = bpfa_pkg::S_IDLE;
      end
      bpfa_pkg::S_IDLE: begin
        if (in_xfer) state_nxt = bpfa_pkg::S_DECIDE;
      end
      bpfa_pkg::S_DECIDE: begin
        priority if (count_r == '0) begin
          state_nxt = bpfa_pkg::S_RESP;
        end else if (op_r == bpfa_pkg::OP_FREE) begin
          state_nxt = (free_hi > FW'(start_r)) ? bpfa_pkg::S_MOD_RD : bpfa_pkg::S_RESP;
        end else if (count_r > bpfa_pkg::COUNT_W'(bpfa_pkg::MAX_RUN)) begin
          state_nxt = bpfa_pkg::S_RESP;
        end else begin
          state_nxt = bpfa_pkg::S_SCAN;
        end
      end
      bpfa_pkg::S_SCAN: begin
        priority if (found) begin
          state_nxt = bpfa_pkg::S_MOD_RD;
        end else if (pass_end && pass_r) begin
          state_nxt = bpfa_pkg::S_RESP;
        end else begin
          state_nxt = bpfa_pkg::S_SCAN;
        end
      end
      bpfa_pkg::S_MOD_RD: state_nxt = bpfa_pkg::S_MOD_WR;
      bpfa_pkg::S_MOD_WR: begin
        state_nxt = mod_last ? bpfa_pkg::S_RESP : bpfa_pkg::S_MOD_RD;
      end
      bpfa_pkg::S_RESP: begin
        if (!out_valid_r || out_ready) state_nxt = bpfa_pkg::S_IDLE;
      end
      default: state_nxt = bpfa_pkg::S_CLEAR;
    endcase
  end

  // datapath and result updates
  always_comb begin
    clr_cnt_nxt    = clr_cnt_r;
    cursor_nxt     = cursor_r;
    pass_nxt       = pass_r;
    from_nxt       = from_r;
    issue_word_nxt = issue_word_r;
    eval_word_nxt  = issue_word_r[AW-1:0];
    eval_vld_nxt   = issue_ok && !found;
    run_len_nxt    = run_len_r;
    run_start_nxt  = run_start_r;
    lo_nxt         = lo_r;
    hi_nxt         = hi_r;
    mod_word_nxt   = mod_word_r;
    set_nxt        = set_r;
    status_nxt     = status_r;
    grant_nxt      = grant_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_status_nxt = out_status_r;
    out_grant_nxt  = out_grant_r;

    unique case (state_r)
      bpfa_pkg::S_CLEAR: clr_cnt_nxt = clr_cnt_r + AW'(1);
      bpfa_pkg::S_DECIDE: begin
        status_nxt = bpfa_pkg::STATUS_OK;
        grant_nxt  = '0;
        priority if (count_r == '0) begin
          status_nxt = bpfa_pkg::STATUS_ZERO;
        end else if (op_r == bpfa_pkg::OP_FREE) begin
          lo_nxt       = FW'(start_r);
          hi_nxt       = free_hi;
          set_nxt      = 1'b0;
          mod_word_nxt = start_r[BW +: AW];
        end else if (count_r > bpfa_pkg::COUNT_W'(bpfa_pkg::MAX_RUN)) begin
          status_nxt = bpfa_pkg::STATUS_NO_RUN;
        end else begin
          pass_nxt       = 1'b0;
          from_nxt       = cursor_r;
          issue_word_nxt = cursor_r[FW-1:BW];
          run_len_nxt    = '0;
        end
      end
      bpfa_pkg::S_SCAN: begin
        if (issue_ok) issue_word_nxt = issue_word_r + 1'b1;
        priority if (found) begin
          lo_nxt       = found_frame;
          hi_nxt       = found_frame + FW'(count_r);
          set_nxt      = 1'b1;
          mod_word_nxt = found_frame[BW +: AW];
          grant_nxt    = found_frame[bpfa_pkg::GRANT_W-1:0];
          cursor_nxt   = found_frame + FW'(count_r);
        end else if (eval_vld_r) begin
          if (lz == CW'(bpfa_pkg::WORD_BITS)) begin
            run_len_nxt   = (run_sum > (RW+1)'(bpfa_pkg::MAX_RUN)) ?
                            RW'(bpfa_pkg::MAX_RUN) : run_sum[RW-1:0];
            run_start_nxt = run_head;
          end else begin
            run_len_nxt   = RW'(lz);
            run_start_nxt = eval_base + FW'(bpfa_pkg::WORD_BITS) - FW'(lz);
          end
        end else if (pass_end && !pass_r) begin
          pass_nxt       = 1'b1;
          from_nxt       = '0;
          issue_word_nxt = '0;
          run_len_nxt    = '0;
        end else if (pass_end) begin
          status_nxt = bpfa_pkg::STATUS_NO_RUN;
          cursor_nxt = fail_cursor;
        end
      end
      bpfa_pkg::S_MOD_WR: mod_word_nxt = mod_word_r + AW'(1);
      bpfa_pkg::S_RESP: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = status_r;
          out_grant_nxt  = grant_r;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= bpfa_pkg::S_CLEAR;
      clr_cnt_r     <= '0;
      frame_count_r <= '0;
      cursor_r      <= '0;
      eval_vld_r    <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      cursor_r    <= cursor_nxt;
      eval_vld_r  <= eval_vld_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr) frame_count_r <= pwdata[FW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      op_r    <= in_operation;
      start_r <= in_start_frame;
      count_r <= in_page_count;
    end
    pass_r       <= pass_nxt;
    from_r       <= from_nxt;
    issue_word_r <= issue_word_nxt;
    eval_word_r  <= eval_word_nxt;
    run_len_r    <= run_len_nxt;
    run_start_r  <= run_start_nxt;
    lo_r         <= lo_nxt;
    hi_r         <= hi_nxt;
    mod_word_r   <= mod_word_nxt;
    set_r        <= set_nxt;
    status_r     <= status_nxt;
    grant_r      <= grant_nxt;
    out_status_r <= out_status_nxt;
    out_grant_r  <= out_grant_nxt;
  end

endmodule

FILE: sv/bpfa_checker.sv
`timescale 1ns / 1ps
// port-level assertions for the page frame allocator, bound to the top level
// depends on bpfa_pkg and bitmap_page_frame_allocator

module bpfa_port_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [bpfa_pkg::STATUS_W-1:0] out_status,
  input logic [bpfa_pkg::GRANT_W-1:0]  out_granted_frame
);

  // clearing pass follows reset
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_ready)
    else $error("result or request transfer enabled right after reset");

  // one request in flight
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while another is in progress");

  a_no_grant_on_error: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != bpfa_pkg::STATUS_OK) |-> out_granted_frame == '0)
    else $error("nonzero frame reported with an error status");

  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) &&
                                $stable(out_granted_frame))
    else $error("stalled result changed or dropped");

endmodule

bind bitmap_page_frame_allocator bpfa_port_checker u_bpfa_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_valid),
  .in_ready          (in_ready),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .out_status        (out_status),
  .out_granted_frame (out_granted_frame)
);
